// ----- sv/qsl_pkg.sv -----
// Package for the quicksort (Lomuto) sorter: sizes, index types, state codes
// and the record that carries one sorted element to the output stage.
// No dependencies.
package qsl_pkg;

   localparam int MAX_ELEMS = 16;
   localparam int DATA_W    = 32;
   localparam int IDX_W     = $clog2(MAX_ELEMS);
   localparam int CNT_W     = $clog2(MAX_ELEMS + 1);
   localparam int STK_D     = MAX_ELEMS / 2;
   localparam int SPA_W     = $clog2(STK_D);
   localparam int SP_W      = $clog2(STK_D + 1);

   typedef logic [DATA_W-1:0] data_type;
   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [SP_W-1:0]   sp_type;

   typedef struct packed {
      idx_type lo;
      idx_type hi;
   } range_type;

   typedef struct packed {
      logic     valid;
      data_type value;
      logic     last;
      logic     ovf;
   } emit_type;

   typedef enum logic [15:0] {
      ST_LOAD     = 16'h0001,
      ST_INIT     = 16'h0002,
      ST_POP      = 16'h0004,
      ST_POP_WAIT = 16'h0008,
      ST_PIV      = 16'h0010,
      ST_SCAN     = 16'h0020,
      ST_SWAP_WR1 = 16'h0040,
      ST_SWAP_WR2 = 16'h0080,
      ST_FIN_WR1  = 16'h0100,
      ST_FIN_WR2  = 16'h0200,
      ST_PUSH_LO  = 16'h0400,
      ST_PUSH_HI  = 16'h0800,
      ST_EMIT_RD  = 16'h1000,
      ST_EMIT_OUT = 16'h2000
   } state_type;

endpackage

// ----- sv/quicksort_lomuto_sorter.sv -----
// Top level of the quicksort (Lomuto) sorter: sequencer plus output register.
// Depends on qsl_pkg, qsl_core, qsl_cmp.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_stall | req_value, req_last_element
//   rsp     | out       | rsp_valid / rsp_stall | rsp_sorted_value, rsp_last_result,
//           |           |                       | rsp_overflowed
//
// Loading takes requests without stalling; items beyond 16 are dropped and flagged.
// The request marked last starts the sort; each compare step of the partition loop
// is paced by the single store read port and the shared comparator.
// Read-out then gives one result per cycle unless rsp_stall holds the output;
// req_stall stays high until the last result has moved into the output register.
// Reset (synchronous) empties the set and the range stack.
module quicksort_lomuto_sorter
   import qsl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_value,
   input  logic        req_last_element,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_sorted_value,
   output logic        rsp_last_result,
   output logic        rsp_overflowed
);

   emit_type emit;
   logic     emit_take;
   logic     rsp_valid_ff, rsp_valid_in;
   data_type value_ff;
   logic     last_ff, ovf_ff;

   qsl_core u_core (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_value  (req_value),
      .in_last   (req_last_element),
      .in_stall  (req_stall),
      .emit      (emit),
      .emit_take (emit_take)
   );

   assign emit_take    = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = emit_take ? emit.valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_take && emit.valid) begin
         value_ff <= emit.value;
         last_ff  <= emit.last;
         ovf_ff   <= emit.ovf;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sorted_value = value_ff;
   assign rsp_last_result  = last_ff;
   assign rsp_overflowed   = ovf_ff;

endmodule

// ----- sv/qsl_cmp.sv -----
// Shared signed compare unit: a <= b on 32-bit two's complement values.
// Depends on qsl_pkg.
module qsl_cmp
   import qsl_pkg::*;
(
   input  data_type a,
   input  data_type b,
   output logic     le
);

   assign le = ($signed(a) <= $signed(b));

endmodule

// ----- sv/qsl_core.sv -----
// Sequencer of the sorter: element store, range stack, Lomuto partition loop
// and read-out of the sorted set. Uses qsl_cmp; depends on qsl_pkg.
module qsl_core
   import qsl_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  data_type in_value,
   input  logic     in_last,
   output logic     in_stall,
   output emit_type emit,
   input  logic     emit_take
);

   state_type state_ff, state_in;
   cnt_type   count_ff, count_in;
   logic      ovf_ff, ovf_in;
   sp_type    sp_ff, sp_in;
   idx_type   lo_ff, lo_in, hi_ff, hi_in;
   idx_type   j_ff, j_in, st_ff, st_in, k_ff, k_in;
   data_type  pivot_ff, pivot_in, tmp_ff, tmp_in;

   data_type  store_ff [MAX_ELEMS];
   data_type  mem_q_ff;
   idx_type   mem_ra, mem_wa;
   data_type  mem_wd;
   logic      mem_we;

   range_type stk_ff [STK_D];
   range_type stk_q_ff;
   logic [SPA_W-1:0] stk_ra;
   range_type stk_wd;
   logic      stk_we;

   logic      le;
   idx_type   j_next;
   cnt_type   lo_p1, p_p1;
   sp_type    sp_m1;

   qsl_cmp u_cmp (
      .a  (mem_q_ff),
      .b  (pivot_ff),
      .le (le)
   );

   assign j_next = j_ff + idx_type'(1);
   assign lo_p1  = {1'b0, lo_ff} + cnt_type'(1);
   assign p_p1   = {1'b0, st_ff} + cnt_type'(1);
   assign sp_m1  = sp_ff - sp_type'(1);
   assign in_stall = (state_ff != ST_LOAD);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      sp_in    = sp_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      j_in     = j_ff;
      st_in    = st_ff;
      k_in     = k_ff;
      pivot_in = pivot_ff;
      tmp_in   = tmp_ff;
      mem_ra   = j_ff;
      mem_wa   = count_ff[IDX_W-1:0];
      mem_wd   = in_value;
      mem_we   = 1'b0;
      stk_ra   = sp_m1[SPA_W-1:0];
      stk_wd   = '{lo: lo_ff, hi: hi_ff};
      stk_we   = 1'b0;
      emit.valid = 1'b0;
      emit.value = mem_q_ff;
      emit.last  = ({1'b0, k_ff} + cnt_type'(1) == count_ff);
      emit.ovf   = ovf_ff;

      case (state_ff)
         ST_LOAD: begin
            if (in_valid) begin
               if (count_ff < cnt_type'(MAX_ELEMS)) begin
                  mem_we   = 1'b1;
                  count_in = count_ff + cnt_type'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (in_last) begin
                  state_in = ST_INIT;
               end
            end
         end
         ST_INIT: begin
            sp_in = '0;
            k_in  = '0;
            if (count_ff < cnt_type'(2)) begin
               state_in = ST_EMIT_RD;
            end else begin
               stk_wd   = '{lo: '0, hi: idx_type'(count_ff - cnt_type'(1))};
               stk_we   = 1'b1;
               sp_in    = sp_type'(1);
               state_in = ST_POP;
            end
         end
         ST_POP: begin
            if (sp_ff == '0) begin
               k_in     = '0;
               state_in = ST_EMIT_RD;
            end else begin
               sp_in    = sp_m1;
               state_in = ST_POP_WAIT;
            end
         end
         ST_POP_WAIT: begin
            lo_in = stk_q_ff.lo;
            hi_in = stk_q_ff.hi;
            j_in  = stk_q_ff.lo;
            st_in = stk_q_ff.lo;
            mem_ra = stk_q_ff.hi;
            if (stk_q_ff.lo >= stk_q_ff.hi) begin
               state_in = ST_POP;
            end else begin
               state_in = ST_PIV;
            end
         end
         ST_PIV: begin
            pivot_in = mem_q_ff;
            mem_ra   = j_ff;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (le && (st_ff != j_ff)) begin
               tmp_in   = mem_q_ff;
               mem_ra   = st_ff;
               state_in = ST_SWAP_WR1;
            end else begin
               if (le) begin
                  st_in = st_ff + idx_type'(1);
               end
               j_in   = j_next;
               mem_ra = j_next;
               if (j_next == hi_ff) begin
                  mem_ra = le ? st_ff + idx_type'(1) : st_ff;
                  if ((le ? st_ff + idx_type'(1) : st_ff) == hi_ff) begin
                     state_in = ST_PUSH_LO;
                  end else begin
                     state_in = ST_FIN_WR1;
                  end
               end
            end
         end
         ST_SWAP_WR1: begin
            mem_we   = 1'b1;
            mem_wa   = j_ff;
            mem_wd   = mem_q_ff;
            state_in = ST_SWAP_WR2;
         end
         ST_SWAP_WR2: begin
            mem_we = 1'b1;
            mem_wa = st_ff;
            mem_wd = tmp_ff;
            st_in  = st_ff + idx_type'(1);
            j_in   = j_next;
            mem_ra = j_next;
            if (j_next == hi_ff) begin
               mem_ra = st_ff + idx_type'(1);
               if (st_ff + idx_type'(1) == hi_ff) begin
                  state_in = ST_PUSH_LO;
               end else begin
                  state_in = ST_FIN_WR1;
               end
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_FIN_WR1: begin
            mem_we   = 1'b1;
            mem_wa   = hi_ff;
            mem_wd   = mem_q_ff;
            state_in = ST_FIN_WR2;
         end
         ST_FIN_WR2: begin
            mem_we   = 1'b1;
            mem_wa   = st_ff;
            mem_wd   = pivot_ff;
            state_in = ST_PUSH_LO;
         end
         ST_PUSH_LO: begin
            stk_wd = '{lo: lo_ff, hi: st_ff - idx_type'(1)};
            if (({1'b0, st_ff} > lo_p1) && (sp_ff < sp_type'(STK_D))) begin
               stk_we = 1'b1;
               sp_in  = sp_ff + sp_type'(1);
            end
            state_in = ST_PUSH_HI;
         end
         ST_PUSH_HI: begin
            stk_wd = '{lo: st_ff + idx_type'(1), hi: hi_ff};
            if ((p_p1 < {1'b0, hi_ff}) && (sp_ff < sp_type'(STK_D))) begin
               stk_we = 1'b1;
               sp_in  = sp_ff + sp_type'(1);
            end
            state_in = ST_POP;
         end
         ST_EMIT_RD: begin
            mem_ra   = k_ff;
            state_in = ST_EMIT_OUT;
         end
         ST_EMIT_OUT: begin
            emit.valid = 1'b1;
            mem_ra     = k_ff;
            if (emit_take) begin
               if (emit.last) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
                  sp_in    = '0;
                  state_in = ST_LOAD;
               end else begin
                  k_in   = k_ff + idx_type'(1);
                  mem_ra = k_ff + idx_type'(1);
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         sp_ff    <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         sp_ff    <= sp_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      j_ff     <= j_in;
      st_ff    <= st_in;
      k_ff     <= k_in;
      pivot_ff <= pivot_in;
      tmp_ff   <= tmp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_ff[mem_wa] <= mem_wd;
      end
      mem_q_ff <= store_ff[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_ff[sp_ff[SPA_W-1:0]] <= stk_wd;
      end
      stk_q_ff <= stk_ff[stk_ra];
   end

endmodule
